[rtl/bridge_adc_serial_reader_calibrator_unit_assert.svh]
// assertion macros for the bridge adc reader blocks
// expects clk and rst_n in the scope of each use
`ifndef BRIDGE_ADC_SERIAL_READER_CALIBRATOR_UNIT_ASSERT_SVH
`define BRIDGE_ADC_SERIAL_READER_CALIBRATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define BASCU_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BASCU_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/bascu_pkg.sv]
// shared types, constants and helpers for the bridge adc reader
// no dependencies
package bascu_pkg;

  // sizes
  localparam int unsigned QueueDepth = 8;
  localparam int unsigned WordBits   = 24;
  localparam int unsigned RawW       = 25;
  localparam int unsigned VoltW      = 32;
  localparam int unsigned PressW     = 31;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 32;

  // bit count loaded when a conversion starts
  localparam logic [4:0] WORD_BITS_INIT = 5'd24;

  // 4.91 V reference in mV, applied before the gain shift
  localparam logic signed [13:0] MV_SCALE = 14'sd4910;

  // gain codes
  localparam logic [1:0] GAIN_128 = 2'd0;
  localparam logic [1:0] GAIN_64  = 2'd1;
  localparam logic [1:0] GAIN_32  = 2'd2;

  // register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_GAIN_CODE       = 3'd0,
    CFG_INVERT_SIGN     = 3'd1,
    CFG_VOLT_OFFSET     = 3'd2,
    CFG_VOLT_SCALE_INV  = 3'd3,
    CFG_PRESS_OFFSET    = 3'd4,
    CFG_PRESS_SCALE_INV = 3'd5
  } cfg_idx_t;

  // register reset values
  localparam logic signed [31:0] PRESS_SCALE_INV_RST = 32'sd65536;

  // one classified tick, front to back
  typedef struct packed {
    logic        sck;
    logic        done;
    logic [23:0] word;
    logic [1:0]  gain;
    logic        invert;
  } item_t;

  // calibration registers
  typedef struct packed {
    logic signed [31:0] volt_offset;
    logic signed [31:0] volt_scale_inv;
    logic signed [31:0] press_offset;
    logic signed [31:0] press_scale_inv;
  } cal_t;

  // extra clock pulses that select the next gain
  function automatic logic [1:0] pulse_count(input logic [1:0] gain);
    logic [1:0] cnt;
    case (gain)
      GAIN_64: cnt = 2'd3;
      GAIN_32: cnt = 2'd2;
      default: cnt = 2'd1;
    endcase
    return cnt;
  endfunction

endpackage

[rtl/bascu_front.sv]
// serial clock sequencer: walks the 24 data bits and gain pulses per tick
// depends on bascu_pkg
module bascu_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept_i,
  input  logic                dout_i,
  input  logic [1:0]          gain_i,
  input  logic                invert_i,
  output bascu_pkg::item_t    item_o
);

  typedef enum logic [4:0] {
    PH_IDLE       = 5'b00001,
    PH_BIT_HIGH   = 5'b00010,
    PH_BIT_LOW    = 5'b00100,
    PH_PULSE_HIGH = 5'b01000,
    PH_PULSE_LOW  = 5'b10000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [4:0]  bits_r, bits_nxt;
  logic [1:0]  pulses_r, pulses_nxt;
  logic [23:0] word_r, word_nxt;

  // next state and the item for this tick
  always_comb begin
    phase_nxt     = phase_r;
    bits_nxt      = bits_r;
    pulses_nxt    = pulses_r;
    word_nxt      = word_r;
    item_o.sck    = 1'b0;
    item_o.done   = 1'b0;
    item_o.word   = word_r;
    item_o.gain   = gain_i;
    item_o.invert = invert_i;
    unique case (phase_r)
      PH_BIT_HIGH: begin
        item_o.sck = 1'b1;
        phase_nxt  = PH_BIT_LOW;
      end
      PH_BIT_LOW: begin
        word_nxt = {word_r[22:0], dout_i};
        bits_nxt = bits_r - 5'd1;
        if (bits_nxt == 5'd0) begin
          pulses_nxt = bascu_pkg::pulse_count(gain_i);
          phase_nxt  = PH_PULSE_HIGH;
        end else begin
          phase_nxt = PH_BIT_HIGH;
        end
      end
      PH_PULSE_HIGH: begin
        item_o.sck = 1'b1;
        phase_nxt  = PH_PULSE_LOW;
      end
      PH_PULSE_LOW: begin
        pulses_nxt = pulses_r - 2'd1;
        if (pulses_nxt == 2'd0) begin
          item_o.done = 1'b1;
          phase_nxt   = PH_IDLE;
        end else begin
          phase_nxt = PH_PULSE_HIGH;
        end
      end
      default: begin
        // idle, and any stray code, waits for data low
        phase_nxt = PH_IDLE;
        if (!dout_i) begin
          bits_nxt  = bascu_pkg::WORD_BITS_INIT;
          word_nxt  = '0;
          phase_nxt = PH_BIT_HIGH;
        end
      end
    endcase
  end

  // sequencer state advances once per accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      bits_r   <= '0;
      pulses_r <= '0;
      word_r   <= '0;
    end else if (accept_i) begin
      phase_r  <= phase_nxt;
      bits_r   <= bits_nxt;
      pulses_r <= pulses_nxt;
      word_r   <= word_nxt;
    end
  end

endmodule

[rtl/bascu_queue.sv]
// small request queue between the sequencer and the arithmetic back end
// depends on bascu_pkg and the assertion macro header
`include "bridge_adc_serial_reader_calibrator_unit_assert.svh"
module bascu_queue #(
  parameter int unsigned Depth = bascu_pkg::QueueDepth
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_i,
  input  bascu_pkg::item_t push_item_i,
  input  logic             pop_i,
  output bascu_pkg::item_t head_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  bascu_pkg::item_t   mem_r [Depth];
  logic [AddrW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0]    count_r;
  logic               do_push, do_pop;

  assign full_o  = (count_r == CntW'(Depth));
  assign empty_o = (count_r == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AddrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AddrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + CntW'(do_push) - CntW'(do_pop);
    end
  end

  `BASCU_ASSERT_NEXT(a_push_fills, do_push && !do_pop, !empty_o, "queue empty after a push")

endmodule

[rtl/bascu_back.sv]
// arithmetic back end: scaling, calibration, pressure, and the result register
// depends on bascu_pkg and the assertion macro header
`include "bridge_adc_serial_reader_calibrator_unit_assert.svh"
module bascu_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty_i,
  input  bascu_pkg::item_t     q_head_i,
  output logic                 q_pop_o,
  input  bascu_pkg::cal_t      cal_i,
  input  logic                 out_pop_i,
  output logic                 out_empty_o,
  output logic                 out_sck_o,
  output logic                 out_done_o,
  output logic signed [24:0]   out_raw_o,
  output logic signed [31:0]   out_volt_o,
  output logic [30:0]          out_press_o
);

  typedef enum logic [5:0] {
    BK_IDLE  = 6'b000001,
    BK_SCALE = 6'b000010,
    BK_VMUL  = 6'b000100,
    BK_VCORR = 6'b001000,
    BK_PMUL  = 6'b010000,
    BK_PFIN  = 6'b100000
  } back_state_t;

  localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
  localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

  back_state_t        state_r, state_nxt;
  // result register
  logic               out_valid_r, out_valid_nxt;
  logic               out_sck_r, out_sck_nxt;
  logic               out_done_r, out_done_nxt;
  logic signed [24:0] out_raw_r, out_raw_nxt;
  logic signed [31:0] out_volt_r, out_volt_nxt;
  logic [30:0]        out_press_r, out_press_nxt;
  // working registers
  logic signed [24:0] raw_w_r, raw_w_nxt;
  logic signed [37:0] prod_r, prod_nxt;
  logic [1:0]         gain_r, gain_nxt;
  logic signed [31:0] vnew_r, vnew_nxt;
  logic signed [32:0] diff_r, diff_nxt;
  logic signed [64:0] mul_r, mul_nxt;

  logic               out_free;
  logic               corr_en;
  logic signed [24:0] raw_ext, raw_in;
  logic signed [37:0] prod_in;
  logic signed [38:0] v0_wide;
  logic signed [31:0] v0, vsat, v1;
  logic signed [32:0] vdiff, pdiff;
  logic signed [65:0] rnd_wide;
  logic [30:0]        pclamp;
  logic signed [31:0] scale_sel;

  assign out_free = !out_valid_r || out_pop_i;
  assign corr_en  = (cal_i.volt_offset != '0) || (cal_i.volt_scale_inv != '0);

  // sign-extended, optionally negated reading and its mV product
  assign raw_ext = {q_head_i.word[23], q_head_i.word};
  assign raw_in  = q_head_i.invert ? -raw_ext : raw_ext;
  assign prod_in = 38'(raw_in) * 38'(bascu_pkg::MV_SCALE);

  // gain shift with round half up
  always_comb begin
    case (gain_r)
      bascu_pkg::GAIN_64: v0_wide = (39'(prod_r) + 39'sd8192) >>> 14;
      bascu_pkg::GAIN_32: v0_wide = (39'(prod_r) + 39'sd4096) >>> 13;
      default:            v0_wide = (39'(prod_r) + 39'sd16384) >>> 15;
    endcase
  end
  assign v0    = v0_wide[31:0];
  assign vdiff = 33'(v0) - 33'(cal_i.volt_offset);

  // Q16 rounding of the shared product, then saturate or clamp
  assign rnd_wide = (66'(mul_r) + 66'sd32768) >>> 16;
  always_comb begin
    if (rnd_wide > SAT_MAX) begin
      vsat = 32'sh7FFFFFFF;
    end else if (rnd_wide < SAT_MIN) begin
      vsat = 32'sh80000000;
    end else begin
      vsat = rnd_wide[31:0];
    end
    if (rnd_wide <= 66'sd0) begin
      pclamp = '0;
    end else if (rnd_wide > SAT_MAX) begin
      pclamp = 31'h7FFFFFFF;
    end else begin
      pclamp = rnd_wide[30:0];
    end
  end
  assign v1    = corr_en ? vsat : vnew_r;
  assign pdiff = 33'(v1) - 33'(cal_i.press_offset);

  // one multiplier shared by the voltage and pressure corrections
  assign scale_sel = (state_r == BK_VMUL) ? cal_i.volt_scale_inv : cal_i.press_scale_inv;
  assign mul_nxt   = 65'(diff_r) * 65'(scale_sel);

  // sequencer for one reading, pass-through for plain ticks
  always_comb begin
    state_nxt     = state_r;
    q_pop_o       = 1'b0;
    out_valid_nxt = out_valid_r && !out_pop_i;
    out_sck_nxt   = out_sck_r;
    out_done_nxt  = out_done_r;
    out_raw_nxt   = out_raw_r;
    out_volt_nxt  = out_volt_r;
    out_press_nxt = out_press_r;
    raw_w_nxt     = raw_w_r;
    prod_nxt      = prod_r;
    gain_nxt      = gain_r;
    vnew_nxt      = vnew_r;
    diff_nxt      = diff_r;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty_i && out_free) begin
          q_pop_o = 1'b1;
          if (q_head_i.done) begin
            raw_w_nxt = raw_in;
            prod_nxt  = prod_in;
            gain_nxt  = q_head_i.gain;
            state_nxt = BK_SCALE;
          end else begin
            out_valid_nxt = 1'b1;
            out_sck_nxt   = q_head_i.sck;
            out_done_nxt  = 1'b0;
          end
        end
      end
      BK_SCALE: begin
        vnew_nxt  = v0;
        diff_nxt  = vdiff;
        state_nxt = BK_VMUL;
      end
      BK_VMUL: begin
        state_nxt = BK_VCORR;
      end
      BK_VCORR: begin
        vnew_nxt  = v1;
        diff_nxt  = pdiff;
        state_nxt = BK_PMUL;
      end
      BK_PMUL: begin
        state_nxt = BK_PFIN;
      end
      BK_PFIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_sck_nxt   = 1'b0;
          out_done_nxt  = 1'b1;
          out_raw_nxt   = raw_w_r;
          out_volt_nxt  = vnew_r;
          out_press_nxt = pclamp;
          state_nxt     = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // control and held readings
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
      out_sck_r   <= 1'b0;
      out_done_r  <= 1'b0;
      out_raw_r   <= '0;
      out_volt_r  <= '0;
      out_press_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      out_sck_r   <= out_sck_nxt;
      out_done_r  <= out_done_nxt;
      out_raw_r   <= out_raw_nxt;
      out_volt_r  <= out_volt_nxt;
      out_press_r <= out_press_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    raw_w_r <= raw_w_nxt;
    prod_r  <= prod_nxt;
    gain_r  <= gain_nxt;
    vnew_r  <= vnew_nxt;
    diff_r  <= diff_nxt;
    mul_r   <= mul_nxt;
  end

  assign out_empty_o = !out_valid_r;
  assign out_sck_o   = out_sck_r;
  assign out_done_o  = out_done_r;
  assign out_raw_o   = out_raw_r;
  assign out_volt_o  = out_volt_r;
  assign out_press_o = out_press_r;

  `BASCU_ASSERT_IMPL(a_no_pop_busy, state_r != BK_IDLE, !q_pop_o, "queue popped mid reading")
  `BASCU_ASSERT_IMPL(a_done_low, out_valid_r && out_done_r, !out_sck_r, "reading on high clock")
  `BASCU_ASSERT_NEXT(a_scale_seq, state_r == BK_SCALE, state_r == BK_VMUL, "scale not followed by multiply")

endmodule

[rtl/bridge_adc_serial_reader_calibrator_unit.sv]
// bridge adc serial reader: one tick per cycle in while the queue is not full,
// one result per tick out. plain tick: through the queue, then the result register.
// reading tick: scale step and two passes through the shared 33x32 multiplier,
// no new tick taken meanwhile; an 8-entry queue absorbs that stall.
// throughput one tick per cycle between readings while results are popped;
// reset (synchronous, rst_n low) clears sequencer, queue, readings, registers.
module bridge_adc_serial_reader_calibrator_unit #(
  parameter int unsigned QueueDepth = bascu_pkg::QueueDepth
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // tick requests
  input  logic                 in_push,
  output logic                 in_full,
  input  logic                 in_dout,
  // results
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic                 out_sck,
  output logic                 out_done_res,
  output logic signed [24:0]   out_raw_value,
  output logic signed [31:0]   out_voltage_mv,
  output logic [30:0]          out_pressure,
  // configuration writes
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_wdata
);

  logic [1:0]         gain_code_r;
  logic               invert_r;
  logic signed [31:0] volt_offset_r, volt_scale_inv_r, press_offset_r, press_scale_inv_r;
  bascu_pkg::cal_t    cal;
  bascu_pkg::item_t   front_item, q_head;
  logic               accept, q_empty, q_pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_code_r       <= bascu_pkg::GAIN_128;
      invert_r          <= 1'b0;
      volt_offset_r     <= '0;
      volt_scale_inv_r  <= '0;
      press_offset_r    <= '0;
      press_scale_inv_r <= bascu_pkg::PRESS_SCALE_INV_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bascu_pkg::CFG_GAIN_CODE:       gain_code_r       <= cfg_wdata[1:0];
        bascu_pkg::CFG_INVERT_SIGN:     invert_r          <= cfg_wdata[0];
        bascu_pkg::CFG_VOLT_OFFSET:     volt_offset_r     <= cfg_wdata;
        bascu_pkg::CFG_VOLT_SCALE_INV:  volt_scale_inv_r  <= cfg_wdata;
        bascu_pkg::CFG_PRESS_OFFSET:    press_offset_r    <= cfg_wdata;
        bascu_pkg::CFG_PRESS_SCALE_INV: press_scale_inv_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cal.volt_offset     = volt_offset_r;
  assign cal.volt_scale_inv  = volt_scale_inv_r;
  assign cal.press_offset    = press_offset_r;
  assign cal.press_scale_inv = press_scale_inv_r;

  assign accept = in_push && !in_full;

  // tick sequencer
  bascu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept_i (accept),
    .dout_i   (in_dout),
    .gain_i   (gain_code_r),
    .invert_i (invert_r),
    .item_o   (front_item)
  );

  // decoupling queue
  bascu_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (in_push),
    .push_item_i (front_item),
    .pop_i       (q_pop),
    .head_o      (q_head),
    .full_o      (in_full),
    .empty_o     (q_empty)
  );

  // arithmetic and result register
  bascu_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty_i   (q_empty),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .cal_i       (cal),
    .out_pop_i   (out_pop),
    .out_empty_o (out_empty),
    .out_sck_o   (out_sck),
    .out_done_o  (out_done_res),
    .out_raw_o   (out_raw_value),
    .out_volt_o  (out_voltage_mv),
    .out_press_o (out_pressure)
  );

endmodule

[tb/bascu_tick_checker.sv]
`timescale 1ns / 100ps
// checker for the bridge adc serial reader: predicts the result of every accepted
// tick request and compares it with the result channel, counting mismatches
// depends on bascu_pkg
module bascu_tick_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  logic                in_full,
  input  logic                in_dout,
  input  logic                out_empty,
  input  logic                out_pop,
  input  logic                out_sck,
  input  logic                out_done_res,
  input  logic signed [24:0]  out_raw_value,
  input  logic signed [31:0]  out_voltage_mv,
  input  logic [30:0]         out_pressure,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_wdata,
  output int                  fail_count,
  output int                  pending
);

  typedef logic signed [79:0] wide_t;

  typedef enum logic [4:0] {
    SEQ_IDLE       = 5'b00001,
    SEQ_BIT_HIGH   = 5'b00010,
    SEQ_BIT_LOW    = 5'b00100,
    SEQ_PULSE_HIGH = 5'b01000,
    SEQ_PULSE_LOW  = 5'b10000
  } seq_phase_t;

  typedef struct {
    logic               sck;
    logic               done;
    logic signed [24:0] raw;
    logic signed [31:0] volt;
    logic [30:0]        press;
  } tick_result_t;

  localparam int    MvFullScale = 4910;
  localparam wide_t Int32Max    = (wide_t'(1) <<< 31) - 1;
  localparam wide_t Int32Min    = -(wide_t'(1) <<< 31);

  // calibration copy
  logic [1:0]         gain;
  logic               invert;
  logic signed [31:0] volt_off;
  logic signed [31:0] volt_sinv;
  logic signed [31:0] press_off;
  logic signed [31:0] press_sinv;

  // sequencer copy
  seq_phase_t         phase;
  logic [4:0]         bits_left;
  logic [1:0]         pulses_left;
  logic [23:0]        shift_word;
  logic signed [24:0] held_raw;
  logic signed [31:0] held_volt;
  logic [30:0]        held_press;

  tick_result_t tick_results_q[$];

  // divide by 2^s, nearest, ties upward
  function automatic wide_t round_q(input wide_t x, input int unsigned s);
    return (x + (wide_t'(1) <<< (s - 1))) >>> s;
  endfunction

  // convert the shifted word into raw, millivolts and pressure
  function automatic void convert_reading();
    wide_t       raw;
    wide_t       v;
    wide_t       p;
    int unsigned s;
    raw = wide_t'($signed(shift_word));
    if (invert) raw = -raw;
    held_raw = raw[24:0];
    case (gain)
      bascu_pkg::GAIN_64: s = 14;
      bascu_pkg::GAIN_32: s = 13;
      default:            s = 15;
    endcase
    v = round_q(raw * MvFullScale, s);
    if (volt_off != 0 || volt_sinv != 0) begin
      v = round_q((v - volt_off) * volt_sinv, 16);
      if (v > Int32Max) v = Int32Max;
      else if (v < Int32Min) v = Int32Min;
    end
    held_volt = v[31:0];
    p = round_q((v - press_off) * press_sinv, 16);
    if (p <= 0) p = 0;
    else if (p > Int32Max) p = Int32Max;
    held_press = p[30:0];
  endfunction

  // one tick of the serial clock sequencer
  function automatic void advance_sequencer(input logic d, output tick_result_t r);
    r.sck  = 1'b0;
    r.done = 1'b0;
    case (phase)
      SEQ_BIT_HIGH: begin
        r.sck = 1'b1;
        phase = SEQ_BIT_LOW;
      end
      SEQ_BIT_LOW: begin
        shift_word = {shift_word[22:0], d};
        bits_left  = bits_left - 5'd1;
        if (bits_left == 5'd0) begin
          pulses_left = (gain == bascu_pkg::GAIN_64) ? 2'd3 :
                        (gain == bascu_pkg::GAIN_32) ? 2'd2 : 2'd1;
          phase = SEQ_PULSE_HIGH;
        end else begin
          phase = SEQ_BIT_HIGH;
        end
      end
      SEQ_PULSE_HIGH: begin
        r.sck = 1'b1;
        phase = SEQ_PULSE_LOW;
      end
      SEQ_PULSE_LOW: begin
        pulses_left = pulses_left - 2'd1;
        if (pulses_left == 2'd0) begin
          convert_reading();
          r.done = 1'b1;
          phase  = SEQ_IDLE;
        end else begin
          phase = SEQ_PULSE_HIGH;
        end
      end
      default: begin
        phase = SEQ_IDLE;
        if (!d) begin
          bits_left  = 5'd24;
          shift_word = '0;
          phase      = SEQ_BIT_HIGH;
        end
      end
    endcase
    r.raw   = held_raw;
    r.volt  = held_volt;
    r.press = held_press;
  endfunction

  always @(posedge clk) begin : track
    tick_result_t want;
    tick_result_t fresh;
    if (!rst_n) begin
      gain        = bascu_pkg::GAIN_128;
      invert      = 1'b0;
      volt_off    = '0;
      volt_sinv   = '0;
      press_off   = '0;
      press_sinv  = bascu_pkg::PRESS_SCALE_INV_RST;
      phase       = SEQ_IDLE;
      bits_left   = '0;
      pulses_left = '0;
      shift_word  = '0;
      held_raw    = '0;
      held_volt   = '0;
      held_press  = '0;
      fail_count  = 0;
      tick_results_q.delete();
    end else begin
      // compare a popped result with the oldest prediction
      if (out_pop && !out_empty) begin
        if (tick_results_q.size() == 0) begin
          $error("result popped with no tick request outstanding");
          fail_count++;
        end else begin
          want = tick_results_q.pop_front();
          if (out_sck !== want.sck) begin
            $error("sck: expected %0d, got %0d", want.sck, out_sck);
            fail_count++;
          end
          if (out_done_res !== want.done) begin
            $error("done_res: expected %0d, got %0d", want.done, out_done_res);
            fail_count++;
          end
          if (out_raw_value !== want.raw) begin
            $error("raw_value: expected %0d, got %0d", want.raw, out_raw_value);
            fail_count++;
          end
          if (out_voltage_mv !== want.volt) begin
            $error("voltage_mv: expected %0d, got %0d", want.volt, out_voltage_mv);
            fail_count++;
          end
          if (out_pressure !== want.press) begin
            $error("pressure: expected %0d, got %0d", want.press, out_pressure);
            fail_count++;
          end
        end
      end
      // predict an accepted tick request
      if (in_push && !in_full) begin
        advance_sequencer(in_dout, fresh);
        tick_results_q.push_back(fresh);
      end
      // register writes, unknown indexes ignored
      if (cfg_we) begin
        case (cfg_index)
          bascu_pkg::CFG_GAIN_CODE:       gain       = cfg_wdata[1:0];
          bascu_pkg::CFG_INVERT_SIGN:     invert     = cfg_wdata[0];
          bascu_pkg::CFG_VOLT_OFFSET:     volt_off   = cfg_wdata;
          bascu_pkg::CFG_VOLT_SCALE_INV:  volt_sinv  = cfg_wdata;
          bascu_pkg::CFG_PRESS_OFFSET:    press_off  = cfg_wdata;
          bascu_pkg::CFG_PRESS_SCALE_INV: press_sinv = cfg_wdata;
          default: ;
        endcase
      end
    end
    pending = tick_results_q.size();
  end

endmodule

[tb/tb_bridge_adc_serial_reader_calibrator_unit.sv]
`timescale 1ns / 100ps
// testbench top for the bridge adc serial reader: drives tick requests, register
// writes and result pops, and reports the verdict of bascu_tick_checker
// depends on bascu_pkg, bascu_tick_checker and the block itself
module tb_bridge_adc_serial_reader_calibrator_unit;

  localparam int ItemCount  = 1000;
  localparam int CalmAfter  = 850;
  localparam int HoldAfter  = 300;
  localparam int HoldCycles = 60;
  localparam int CycleLimit = 400000;

  // codes with no name in the package
  localparam logic [1:0] GainCodeSpare = 2'd3;
  localparam logic [2:0] CfgIdxSpareLo = 3'd6;
  localparam logic [2:0] CfgIdxSpareHi = 3'd7;

  logic               clk;
  logic               rst_n;
  logic               in_push;
  logic               in_full;
  logic               in_dout;
  logic               out_empty;
  logic               out_pop;
  logic               out_sck;
  logic               out_done_res;
  logic signed [24:0] out_raw_value;
  logic signed [31:0] out_voltage_mv;
  logic [30:0]        out_pressure;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_wdata;
  int                 fail_count;
  int                 pending;

  int         accepted_ticks = 0;
  int         cycle_count    = 0;
  logic       calm           = 1'b0;
  logic [1:0] gain_cfg       = bascu_pkg::GAIN_128;
  bit         tick_plan[$];

  bridge_adc_serial_reader_calibrator_unit i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_dout        (in_dout),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_sck        (out_sck),
    .out_done_res   (out_done_res),
    .out_raw_value  (out_raw_value),
    .out_voltage_mv (out_voltage_mv),
    .out_pressure   (out_pressure),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  bascu_tick_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side: random pop stalls, one long hold-off to fill the block
  initial begin : receiver
    int held;
    held    = 0;
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      if (held == 0 && accepted_ticks >= HoldAfter) begin
        held = 1;
        out_pop <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk);
      end else if (!calm && rst_n && $urandom_range(0, 5) == 0) begin
        out_pop <= 1'b0;
        repeat ($urandom_range(1, 8) - 1) @(negedge clk);
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // one tick request, with an occasional gap before it
  task automatic send_tick(input logic level);
    @(negedge clk);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_push <= 1'b1;
    in_dout <= level;
    @(posedge clk);
    while (in_full) @(posedge clk);
    accepted_ticks++;
    if (accepted_ticks >= CalmAfter) calm = 1'b1;
  endtask

  // data-low start, 24 clocked bits, then the gain pulses; unsampled ticks are noise
  function automatic void plan_reading(input logic [23:0] word, input int pulses);
    tick_plan.push_back(1'b0);
    for (int i = 23; i >= 0; i--) begin
      tick_plan.push_back(1'($urandom));
      tick_plan.push_back(word[i]);
    end
    repeat (2 * pulses) tick_plan.push_back(1'($urandom));
  endfunction

  task automatic play_ticks(input int count);
    repeat (count) send_tick(tick_plan.pop_front());
  endtask

  task automatic read_word(input logic [23:0] word);
    plan_reading(word, bascu_pkg::pulse_count(gain_cfg));
    play_ticks(tick_plan.size());
  endtask

  // stop sending and wait until every result has come back
  task automatic settle();
    @(negedge clk);
    in_push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx == bascu_pkg::CFG_GAIN_CODE) gain_cfg = data[1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [23:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 24'h80_0000;
      1:       return 24'h7F_FFFF;
      2:       return 24'h00_0000;
      3:       return 24'hFF_FFFF;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_cal();
    case ($urandom_range(0, 5))
      0:       return 32'h0000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h0001_0000 + $urandom_range(0, 8191) - 32'd4096;
      4:       return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
      default: return $urandom;
    endcase
  endfunction

  initial begin : stimulus
    rst_n     = 1'b0;
    in_push   = 1'b0;
    in_dout   = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = bascu_pkg::CFG_GAIN_CODE;
    cfg_wdata = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings, full-scale words, idle ticks with data high
    send_tick(1'b1);
    send_tick(1'b1);
    read_word(24'h7F_FFFF);
    read_word(24'h80_0000);

    // sign inversion of the most negative word, each gain code
    settle();
    write_reg(bascu_pkg::CFG_INVERT_SIGN, 32'd1);
    write_reg(bascu_pkg::CFG_GAIN_CODE, {30'd0, bascu_pkg::GAIN_64});
    read_word(24'h80_0000);
    settle();
    write_reg(bascu_pkg::CFG_GAIN_CODE, {30'd0, bascu_pkg::GAIN_32});
    read_word(24'hFF_FFFF);
    settle();
    write_reg(bascu_pkg::CFG_GAIN_CODE, {30'd0, GainCodeSpare});
    write_reg(bascu_pkg::CFG_INVERT_SIGN, 32'd0);
    read_word(24'h00_0001);

    // zero slope reciprocal with a nonzero offset forces the voltage to zero
    settle();
    write_reg(bascu_pkg::CFG_VOLT_OFFSET, 32'h0001_0000);
    write_reg(bascu_pkg::CFG_VOLT_SCALE_INV, 32'h0000_0000);
    read_word(24'h12_3456);

    // calibration extremes: saturated voltage, clamped pressure
    settle();
    write_reg(bascu_pkg::CFG_VOLT_OFFSET, 32'h8000_0000);
    write_reg(bascu_pkg::CFG_VOLT_SCALE_INV, 32'h7FFF_FFFF);
    write_reg(bascu_pkg::CFG_PRESS_OFFSET, 32'h7FFF_FFFF);
    write_reg(bascu_pkg::CFG_PRESS_SCALE_INV, 32'h8000_0000);
    read_word(24'h7F_FFFF);
    settle();
    write_reg(bascu_pkg::CFG_PRESS_SCALE_INV, 32'h7FFF_FFFF);
    write_reg(CfgIdxSpareLo, $urandom);
    write_reg(CfgIdxSpareHi, $urandom);
    read_word(24'h80_0000);

    // gain changed mid-read: before the pulse count is taken, then before the scale
    settle();
    write_reg(bascu_pkg::CFG_GAIN_CODE, {30'd0, bascu_pkg::GAIN_128});
    plan_reading(24'hA5_5A3C, 3);
    play_ticks(48);
    settle();
    write_reg(bascu_pkg::CFG_GAIN_CODE, {30'd0, bascu_pkg::GAIN_64});
    play_ticks(2);
    settle();
    write_reg(bascu_pkg::CFG_GAIN_CODE, {30'd0, bascu_pkg::GAIN_32});
    play_ticks(tick_plan.size());

    // random settings, mostly well-formed readings, some broken sequences
    while (accepted_ticks < ItemCount) begin
      settle();
      write_reg(bascu_pkg::CFG_GAIN_CODE, $urandom);
      write_reg(bascu_pkg::CFG_INVERT_SIGN, $urandom);
      if ($urandom_range(0, 3) == 0) begin
        write_reg(bascu_pkg::CFG_VOLT_OFFSET, 32'h0000_0000);
        write_reg(bascu_pkg::CFG_VOLT_SCALE_INV, 32'h0000_0000);
      end else begin
        write_reg(bascu_pkg::CFG_VOLT_OFFSET, pick_cal());
        write_reg(bascu_pkg::CFG_VOLT_SCALE_INV, pick_cal());
      end
      write_reg(bascu_pkg::CFG_PRESS_OFFSET, pick_cal());
      write_reg(bascu_pkg::CFG_PRESS_SCALE_INV, pick_cal());
      if ($urandom_range(0, 3) == 0) write_reg(CfgIdxSpareHi, $urandom);
      repeat ($urandom_range(1, 2)) begin
        if ($urandom_range(0, 7) == 0) begin
          // random data pin, then enough data-high ticks to land back in idle
          repeat ($urandom_range(5, 40)) send_tick(1'($urandom));
          repeat (56) send_tick(1'b1);
        end else begin
          repeat ($urandom_range(0, 3)) send_tick(1'b1);
          read_word(pick_word());
        end
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
